/* sv/wtc_pkg.sv */
// Shared types, constants and codes for the word tokenize and count unit.
package wtc_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int MAX_CHARS_DEF     = 49;

    localparam logic [5:0]  MIN_LEN_RESET  = 6'd2;
    localparam logic [10:0] CAPACITY_RESET = 11'd1024;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    localparam logic [7:0] CFG_MIN_WORD_LEN = 8'd0;
    localparam logic [7:0] CFG_CAPACITY     = 8'd1;

    localparam logic [1:0] ST_EXISTING = 2'd0;
    localparam logic [1:0] ST_ADDED    = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_CMP,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic lookup_rd;
        logic step_idx;
        logic mark_found;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic word_ready;
        logic at_end;
        logic match;
        logic out_free;
    } sts_t;

endpackage

/* sv/wtc_ctrl.sv */
// Controller state machine: byte intake, table search sequencing and commit.
module wtc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  wtc_pkg::sts_t sts,
    output wtc_pkg::cmd_t cmd
);

    wtc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wtc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wtc_pkg::S_IDLE: begin
                if (s_valid && sts.word_ready) state_next = wtc_pkg::S_LOOKUP;
            end
            wtc_pkg::S_LOOKUP: begin
                state_next = sts.at_end ? wtc_pkg::S_COMMIT : wtc_pkg::S_CMP;
            end
            wtc_pkg::S_CMP: begin
                state_next = sts.match ? wtc_pkg::S_COMMIT : wtc_pkg::S_LOOKUP;
            end
            wtc_pkg::S_COMMIT: begin
                if (sts.out_free) state_next = wtc_pkg::S_IDLE;
            end
            default: state_next = wtc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            wtc_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            wtc_pkg::S_LOOKUP: begin
                cmd.lookup_rd = !sts.at_end;
            end
            wtc_pkg::S_CMP: begin
                cmd.mark_found = sts.match;
                cmd.step_idx   = !sts.match;
            end
            wtc_pkg::S_COMMIT: begin
                cmd.commit = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

/* sv/wtc_dpath.sv */
// Datapath: tokenizer, word table memories, counters and result register.
module wtc_dpath #(
    parameter int TABLE_ENTRIES = wtc_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CHARS     = wtc_pkg::MAX_CHARS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    s_text_byte,
    input  logic          s_end_of_text,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_index,
    input  logic [10:0]   cfg_data,
    input  wtc_pkg::cmd_t cmd,
    output wtc_pkg::sts_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output logic [9:0]    m_entry_index,
    output logic [31:0]   m_word_count,
    output logic [10:0]   m_distinct_words,
    output logic [31:0]   m_word_total
);

    localparam int LW   = $clog2(MAX_CHARS + 1);
    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int ROWW = MAX_CHARS * 8 + LW;

    logic [5:0]    min_len_reg;
    logic [10:0]   capacity_reg;
    logic [7:0]    word_reg [MAX_CHARS];
    logic [LW-1:0] plen_reg, wlen_reg;
    logic [CW-1:0] idx_reg, distinct_reg;
    logic          found_reg;
    logic [31:0]   total_reg;

    logic [ROWW-1:0] row_mem [TABLE_ENTRIES];
    logic [31:0]     cnt_mem [TABLE_ENTRIES];
    logic [ROWW-1:0] row_q;
    logic [31:0]     cnt_q;

    logic          m_valid_reg;
    logic [1:0]    status_reg;
    logic [9:0]    entry_reg;
    logic [31:0]   count_reg;
    logic [10:0]   distinct_out_reg;
    logic [31:0]   total_out_reg;

    // Tokenizer
    logic          is_wc;
    logic [7:0]    lc;
    logic [LW-1:0] len_inc, close_len;
    logic          close;

    always_comb begin
        is_wc = (s_text_byte >= 8'h41 && s_text_byte <= 8'h5A) ||
                (s_text_byte >= 8'h61 && s_text_byte <= 8'h7A) ||
                s_text_byte == 8'h27 || s_text_byte == 8'h2D;
        lc      = (s_text_byte >= 8'h41 && s_text_byte <= 8'h5A) ?
                  (s_text_byte | 8'h20) : s_text_byte;
        len_inc = plen_reg + LW'(1);
        if (is_wc) begin
            close     = (32'(len_inc) == MAX_CHARS) || s_end_of_text;
            close_len = len_inc;
        end else begin
            close     = plen_reg != '0;
            close_len = plen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && is_wc) begin
            for (int i = 0; i < MAX_CHARS; i++) begin
                if (32'(plen_reg) == i) word_reg[i] <= lc;
            end
        end
        if (cmd.accept) wlen_reg <= close_len;
    end

    // Masked compare of the stored row against the closed word
    logic match;
    always_comb begin
        match = row_q[ROWW-1 -: LW] == wlen_reg;
        for (int i = 0; i < MAX_CHARS; i++) begin
            if (i < 32'(wlen_reg) && row_q[i*8 +: 8] != word_reg[i]) match = 1'b0;
        end
    end

    logic room, out_free;
    assign room     = (32'(distinct_reg) < 32'(capacity_reg)) &&
                      (32'(distinct_reg) < TABLE_ENTRIES);
    assign out_free = !m_valid_reg || m_ready;

    assign sts.word_ready = close && (32'(close_len) >= 32'(min_len_reg));
    assign sts.at_end     = idx_reg == distinct_reg;
    assign sts.match      = match;
    assign sts.out_free   = out_free;

    logic [ROWW-1:0] new_row;
    always_comb begin
        new_row = '0;
        for (int i = 0; i < MAX_CHARS; i++) new_row[i*8 +: 8] = word_reg[i];
        new_row[ROWW-1 -: LW] = wlen_reg;
    end

    // Table memories
    always_ff @(posedge aclk) begin
        if (cmd.lookup_rd) begin
            row_q <= row_mem[idx_reg[AW-1:0]];
            cnt_q <= cnt_mem[idx_reg[AW-1:0]];
        end
        if (cmd.commit && found_reg) begin
            cnt_mem[idx_reg[AW-1:0]] <= (cnt_q == wtc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 32'd1;
        end else if (cmd.commit && room) begin
            row_mem[distinct_reg[AW-1:0]] <= new_row;
            cnt_mem[distinct_reg[AW-1:0]] <= 32'd1;
        end
    end

    // Commit results
    logic [1:0]    st_c;
    logic [31:0]   cnt_c, total_c;
    logic [CW-1:0] slot_c, distinct_c;
    always_comb begin
        total_c = (total_reg == wtc_pkg::COUNT_MAX) ? total_reg : total_reg + 32'd1;
        distinct_c = distinct_reg;
        if (found_reg) begin
            st_c   = wtc_pkg::ST_EXISTING;
            slot_c = idx_reg;
            cnt_c  = (cnt_q == wtc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 32'd1;
        end else if (room) begin
            st_c       = wtc_pkg::ST_ADDED;
            slot_c     = distinct_reg;
            cnt_c      = 32'd1;
            distinct_c = distinct_reg + CW'(1);
        end else begin
            st_c    = wtc_pkg::ST_DROPPED;
            slot_c  = '0;
            cnt_c   = 32'd0;
            total_c = total_reg;
        end
    end

    logic [31:0] slot_w, distinct_w;
    assign slot_w     = 32'(slot_c);
    assign distinct_w = 32'(distinct_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg  <= wtc_pkg::MIN_LEN_RESET;
            capacity_reg <= wtc_pkg::CAPACITY_RESET;
            plen_reg     <= '0;
            idx_reg      <= '0;
            distinct_reg <= '0;
            found_reg    <= 1'b0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == wtc_pkg::CFG_MIN_WORD_LEN) min_len_reg <= cfg_data[5:0];
            if (cfg_we && cfg_index == wtc_pkg::CFG_CAPACITY)     capacity_reg <= cfg_data;
            if (cmd.accept) begin
                plen_reg  <= close ? '0 : (is_wc ? len_inc : plen_reg);
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.step_idx)   idx_reg   <= idx_reg + CW'(1);
            if (cmd.mark_found) found_reg <= 1'b1;
            if (cmd.commit) begin
                distinct_reg <= distinct_c;
                total_reg    <= total_c;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg       <= st_c;
            entry_reg        <= slot_w[9:0];
            count_reg        <= cnt_c;
            distinct_out_reg <= distinct_w[10:0];
            total_out_reg    <= total_c;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_entry_index    = entry_reg;
    assign m_word_count     = count_reg;
    assign m_distinct_words = distinct_out_reg;
    assign m_word_total     = total_out_reg;

endmodule

/* sv/word_tokenize_and_count_unit.sv */
// Top level of the word tokenize and count unit.
// Text enters one byte per item; a byte that does not close a counted word is taken
// without a table search. A byte that closes a word of at least min_word_len characters
// starts a linear search of the word table, which reads and then compares one stored
// word at a time until the word is found or all held entries have been examined; no
// further byte is accepted until the result is committed, which also waits for the
// result register to drain. Bytes are accepted while a finished result waits to be
// taken.
module word_tokenize_and_count_unit #(
    parameter int TABLE_ENTRIES = wtc_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CHARS     = wtc_pkg::MAX_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_entry_index,
    output logic [31:0] m_word_count,
    output logic [10:0] m_distinct_words,
    output logic [31:0] m_word_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    wtc_pkg::cmd_t cmd;
    wtc_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    wtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wtc_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CHARS     (MAX_CHARS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_text_byte      (s_text_byte),
        .s_end_of_text    (s_end_of_text),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_index    (m_entry_index),
        .m_word_count     (m_word_count),
        .m_distinct_words (m_distinct_words),
        .m_word_total     (m_word_total)
    );

endmodule

/* sv/wtc_checker.sv */
// Port-level checks for the word tokenize and count unit, bound to the top level.
module wtc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [9:0]  m_entry_index,
    input logic [31:0] m_word_count,
    input logic [31:0] m_word_total
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_word_count))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == wtc_pkg::ST_EXISTING || m_status == wtc_pkg::ST_ADDED ||
                     m_status == wtc_pkg::ST_DROPPED))
        else $error("bad status code");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == wtc_pkg::ST_DROPPED |-> m_entry_index == '0 && m_word_count == '0)
        else $error("dropped item carries slot or count");

    a_add: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == wtc_pkg::ST_ADDED |-> m_word_count == 32'd1 && m_word_total != '0)
        else $error("new word with bad counts");

endmodule

bind word_tokenize_and_count_unit wtc_checker u_wtc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_index (m_entry_index),
    .m_word_count  (m_word_count),
    .m_word_total  (m_word_total)
);
